[design/aes_pkg.sv]
// Package for the AES-128 CTR stream cipher: types, S-box and round functions.
// No dependencies.
package aes_pkg;

	localparam int RoundCount = 10;
	localparam int QueueDepth = 2;

	typedef enum logic [2:0] {
		REG_KEY_HIGH   = 3'd0,
		REG_KEY_LOW    = 3'd1,
		REG_NONCE_HIGH = 3'd2,
		REG_NONCE_LOW  = 3'd3,
		REG_INIT_CTR   = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_KEYS,
		ST_ROUNDS,
		ST_OUT
	} eng_state_t;

	// one queued transaction from front to back
	typedef struct packed {
		logic [127:0] data;
		logic [4:0]   count;
		logic         start;
		logic         last;
		logic [127:0] key;
		logic [31:0]  ctr_init;
	} job_t;

	function automatic logic [7:0] sbox(input logic [7:0] x);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		return t[x];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	// byte i of a 128-bit block sits at bits 127-8i : 120-8i
	function automatic logic [7:0] get_b(input logic [127:0] s, input int i);
		return s[127 - 8 * i -: 8];
	endfunction

	function automatic logic [127:0] enc_round(input logic [127:0] s, input logic [127:0] rk,
			input logic final_rnd);
		logic [7:0] t [16];
		logic [7:0] a, b, d, e, al;
		logic [127:0] r;
		for (int c = 0; c < 4; c++)
			for (int i = 0; i < 4; i++)
				t[c * 4 + i] = sbox(get_b(s, ((c + i) & 3) * 4 + i));
		if (!final_rnd) begin
			for (int c = 0; c < 4; c++) begin
				a = t[c * 4]; b = t[c * 4 + 1]; d = t[c * 4 + 2]; e = t[c * 4 + 3];
				al = a ^ b ^ d ^ e;
				t[c * 4]     = a ^ al ^ xtime(a ^ b);
				t[c * 4 + 1] = b ^ al ^ xtime(b ^ d);
				t[c * 4 + 2] = d ^ al ^ xtime(d ^ e);
				t[c * 4 + 3] = e ^ al ^ xtime(e ^ a);
			end
		end
		for (int i = 0; i < 16; i++)
			r[127 - 8 * i -: 8] = t[i];
		return r ^ rk;
	endfunction

	function automatic logic [127:0] next_rkey(input logic [127:0] k, input logic [7:0] rc);
		logic [31:0] w0, w1, w2, w3, t;
		w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
		t = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
		w0 = w0 ^ t;
		w1 = w1 ^ w0;
		w2 = w2 ^ w1;
		w3 = w3 ^ w2;
		return {w0, w1, w2, w3};
	endfunction

endpackage

[design/aes_ram.sv]
// Generic single-port-write, registered-read RAM.
// No dependencies.
module aes_ram #(
	parameter int Width = 128,
	parameter int Depth = 11
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

[design/aes_front.sv]
// Front end: accepts input transactions, captures key snapshot, queues jobs.
// Depends on aes_pkg.
module aes_front import aes_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [127:0] in_data,
	input  logic [4:0]   in_count,
	input  logic         in_start,
	input  logic         in_last,
	input  logic [127:0] key,
	input  logic [31:0]  ctr_init,
	output logic         job_valid,
	input  logic         job_ready,
	output job_t         job
);
	localparam int PtrW = $clog2(QueueDepth);

	job_t            q_q [QueueDepth];
	logic [PtrW-1:0] wp_q, rp_q;
	logic [PtrW:0]   cnt_q;
	logic            push, pop;

	assign in_ready  = cnt_q != (PtrW + 1)'(QueueDepth);
	assign job_valid = cnt_q != '0;
	assign push      = in_valid && in_ready;
	assign pop       = job_valid && job_ready;
	assign job       = q_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			q_q[wp_q] <= '{data: in_data, count: in_count, start: in_start, last: in_last,
				key: key, ctr_init: ctr_init};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= (wp_q == PtrW'(QueueDepth - 1)) ? '0 : wp_q + 1'b1;
			if (pop)
				rp_q <= (rp_q == PtrW'(QueueDepth - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (PtrW + 1)'(push) - (PtrW + 1)'(pop);
		end
	end
endmodule

[design/aes_back.sv]
// Back end: key expansion into round-key RAM, iterative rounds, CTR XOR, output register.
// Depends on aes_pkg and aes_ram.
module aes_back import aes_pkg::*; #(
	parameter int Rounds = RoundCount
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         job_valid,
	output logic         job_ready,
	input  job_t         job,
	input  logic [95:0]  nonce,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [127:0] out_data,
	output logic [4:0]   out_count,
	output logic         out_last
);
	localparam int AW = $clog2(Rounds + 1);

	eng_state_t   state_q, state_d;
	logic [AW-1:0] rnd_q;
	logic [127:0] st_q, kexp_q, rk;
	logic [7:0]   rc_q;
	logic [31:0]  ctr_q;
	logic         we;
	logic [AW-1:0] waddr, raddr;
	logic [127:0] wdata, ks, mask, nk;

	assign nk = next_rkey(kexp_q, rc_q);

	always_comb begin
		state_d   = state_q;
		job_ready = 1'b0;
		we        = 1'b0;
		waddr     = rnd_q;
		wdata     = nk;
		raddr     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (job_valid && job.start) begin
					we      = 1'b1;
					waddr   = '0;
					wdata   = job.key;
					state_d = ST_KEYS;
				end else if (job_valid) begin
					state_d = ST_ROUNDS;
				end
			end
			ST_KEYS: begin
				we = 1'b1;
				if (rnd_q == AW'(Rounds))
					state_d = ST_ROUNDS;
			end
			ST_ROUNDS: begin
				raddr = rnd_q;
				if (rnd_q == AW'(Rounds + 1))
					state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid || out_ready) begin
					job_ready = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		if (state_q == ST_ROUNDS)
			raddr = (rnd_q > AW'(Rounds)) ? AW'(Rounds) : rnd_q;
		else
			raddr = '0;
	end

	aes_ram #(.Width(128), .Depth(Rounds + 1)) u_rk (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rk)
	);

	// st_q holds counter block; rnd_q issues reads, rk arrives in the following cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rnd_q     <= '0;
			ctr_q     <= '0;
			out_valid <= 1'b0;
			st_q      <= '0;
			kexp_q    <= '0;
			rc_q      <= '0;
		end else begin
			state_q <= state_d;
			if (out_valid && out_ready)
				out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid && job.start) begin
						kexp_q <= job.key;
						rc_q   <= 8'h01;
						rnd_q  <= AW'(1);
						ctr_q  <= job.ctr_init;
					end else if (job_valid) begin
						rnd_q <= '0;
					end
				end
				ST_KEYS: begin
					kexp_q <= nk;
					rc_q   <= xtime(rc_q);
					rnd_q  <= (rnd_q == AW'(Rounds)) ? '0 : rnd_q + 1'b1;
				end
				ST_ROUNDS: begin
					if (rnd_q == '0)
						st_q <= {nonce, ctr_q};
					else if (rnd_q == AW'(1))
						st_q <= st_q ^ rk;
					else
						st_q <= enc_round(st_q, rk, rnd_q == AW'(Rounds + 1));
					rnd_q <= (rnd_q == AW'(Rounds + 1)) ? '0 : rnd_q + 1'b1;
				end
				ST_OUT: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						ctr_q     <= ctr_q + 32'd1;
					end
				end
				default: ;
			endcase
		end
	end

	assign ks = st_q;
	always_comb begin
		for (int i = 0; i < 16; i++)
			mask[127 - 8 * i -: 8] = (5'(i) < job.count) ? 8'hff : 8'h00;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && (!out_valid || out_ready)) begin
			out_data  <= (job.data ^ ks) & mask;
			out_count <= job.count;
			out_last  <= job.last;
		end
	end
endmodule

[design/aes128_ctr_stream_cipher.sv]
// Top level of the AES-128 CTR stream cipher: config registers, front queue, back engine.
// Depends on aes_pkg, aes_front, aes_back.
//
// Usage: write key, nonce and initial counter through the config port while idle.
// Input transactions on s_axis carry one 16-byte block; tuser = message_start,
// tlast = message_end. Output transactions on m_axis carry the ciphertext block,
// byte count and tlast. A message_start block loads the key into the round-key
// RAM (11 entries, filled by key expansion) and reloads the counter; key changes
// apply only there, nonce changes apply at once.
// Each block passes through the round engine in order: a dispatch state, the load,
// the initial key add and ten rounds, one per cycle from the round-key RAM, and an
// output state; a message start runs key expansion before the load. A two-entry
// queue lets the input side accept while the engine works; the output register
// holds a result while m_axis stalls, and the engine waits for it to drain.
// Reset clears the counter, queue and valids; round keys are undefined until
// the first message start.
module aes128_ctr_stream_cipher import aes_pkg::*; #(
	parameter int Rounds = RoundCount
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [63:0]  cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [135:0] s_axis_tdata, // block_high, block_low, valid_bytes, 3'b0 pad
	input  logic         s_axis_tuser, // message_start
	input  logic         s_axis_tlast,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [135:0] m_axis_tdata, // result_high, result_low, result_bytes, 3'b0 pad
	output logic         m_axis_tlast
);
	logic [63:0] key_high_q, key_low_q, nonce_low_q;
	logic [31:0] nonce_high_q, init_ctr_q;
	logic        job_valid, job_ready;
	job_t        job;
	logic [127:0] out_data;
	logic [4:0]  out_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q   <= '0;
			key_low_q    <= '0;
			nonce_high_q <= '0;
			nonce_low_q  <= '0;
			init_ctr_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KEY_HIGH:   key_high_q   <= cfg_data;
				REG_KEY_LOW:    key_low_q    <= cfg_data;
				REG_NONCE_HIGH: nonce_high_q <= cfg_data[31:0];
				REG_NONCE_LOW:  nonce_low_q  <= cfg_data;
				REG_INIT_CTR:   init_ctr_q   <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	aes_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_data({s_axis_tdata[63:0], s_axis_tdata[127:64]}),
		.in_count(s_axis_tdata[132:128]), .in_start(s_axis_tuser), .in_last(s_axis_tlast),
		.key({key_high_q, key_low_q}), .ctr_init(init_ctr_q),
		.job_valid(job_valid), .job_ready(job_ready), .job(job)
	);

	aes_back #(.Rounds(Rounds)) u_back (
		.clk(clk), .arst_n(arst_n),
		.job_valid(job_valid), .job_ready(job_ready), .job(job),
		.nonce({nonce_high_q, nonce_low_q}),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_data(out_data), .out_count(out_count), .out_last(m_axis_tlast)
	);

	assign m_axis_tdata = {3'b000, out_count, out_data[63:0], out_data[127:64]};

	a_tready_low_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(job_valid && !job_ready && !s_axis_tready) |=> !(s_axis_tvalid && s_axis_tready)
		|| job_ready || $past(job_ready))
		else $error("accept while queue full");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output changed under stall");
	a_one_release: assert property (@(posedge clk) disable iff (!arst_n)
		job_ready |-> job_valid)
		else $error("engine released an empty queue slot");
endmodule
